FILE: rtl/core/bcal_pkg.sv
// ============================================================================
// bcal_pkg
// Shared types, codes and constants of the three-axis bias calibrator.
// ============================================================================
package bcal_pkg;

    // Field widths fixed by the sample format.
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 32;
    localparam int GRAVITY_W = 15;
    localparam int COUNT_REG_W = 10;

    // Default width of the run counter.
    localparam int COUNT_WIDTH_DEF = 10;

    // Item commands.
    localparam logic [1:0] CMD_CORRECT = 2'd0;
    localparam logic [1:0] CMD_CALIB   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_COUNT   = 2'd1;
    localparam logic [1:0] CFG_GRAVITY = 2'd2;

    // Configuration reset values.
    localparam logic                   MODE_RST    = 1'b0;
    localparam logic [COUNT_REG_W-1:0] COUNT_RST   = 10'd200;
    localparam logic [GRAVITY_W-1:0]   GRAVITY_RST = 15'd16384;

    // Calibration modes.
    localparam logic MODE_MEAN = 1'b0;
    localparam logic MODE_MID  = 1'b1;

    // Per-cycle control handed from the sequencer to each axis lane.
    typedef struct packed {
        logic accum;        // fold the held sample into the run
        logic clear;        // clear sum, max, min
        logic div_start;    // launch the mean divide on the current sum
        logic bias_mid;     // store the midpoint of max and min as bias
        logic correct_sel;  // result is sample minus bias, not the bias
    } lane_ctrl_t;

    // Status flags that travel with a result.
    typedef struct packed {
        logic bias_valid;
        logic run_done;
    } out_flags_t;

endpackage

FILE: rtl/core/bcal_div.sv
// ============================================================================
// bcal_div
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating
// toward zero and returning the low 16 bits of the quotient.
// ============================================================================
module bcal_div
    import bcal_pkg::*;
#(
    parameter int DIVISOR_W = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [SAMPLE_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [SUM_W-1:0]     quot_reg, quot_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 ge;
    logic [SUM_W-1:0]     quot_signed;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign ge        = (rem_shift >= {1'b0, dsr_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W - 1);
            neg_next  = dividend[SUM_W-1];
            quot_next = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[SUM_W-2:0], ge};
            rem_next  = ge ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    // Restore the sign of the magnitude quotient and keep 16 bits.
    assign quot_signed = neg_reg ? (~quot_reg + 1'b1) : quot_reg;
    assign quotient    = quot_signed[SAMPLE_W-1:0];
    assign done        = done_reg;

endmodule

FILE: rtl/core/bcal_lane.sv
// ============================================================================
// bcal_lane
// One axis lane: run sum, max and min, midpoint and mean bias, stored bias
// and the corrected sample.
// ============================================================================
module bcal_lane
    import bcal_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lane_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic [GRAVITY_W-1:0]        offset,
    input  logic [COUNT_WIDTH-1:0]      target,
    output logic                        div_done,
    output logic [SAMPLE_W-1:0]         result
);

    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] max_reg, max_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic [SAMPLE_W-1:0]        bias_reg, bias_next;
    logic [SUM_W-1:0]           term;
    logic [SAMPLE_W:0]          mid_sum;
    logic [SAMPLE_W:0]          mid_adj;
    logic [SAMPLE_W-1:0]        quotient;

    // Sample term of the sum, with the gravity offset taken off.
    assign term = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample}
                - {{(SUM_W-GRAVITY_W){1'b0}}, offset};

    // Midpoint: 17-bit sum of max and min, halved toward zero.
    assign mid_sum = {max_reg[SAMPLE_W-1], max_reg} + {min_reg[SAMPLE_W-1], min_reg};
    assign mid_adj = mid_sum + {{SAMPLE_W{1'b0}}, (mid_sum[SAMPLE_W] & mid_sum[0])};

    bcal_div #(
        .DIVISOR_W (COUNT_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (sum_reg),
        .divisor  (target),
        .done     (div_done),
        .quotient (quotient)
    );

    // Run accumulation and bias update.
    always_comb begin
        sum_next  = sum_reg;
        max_next  = max_reg;
        min_next  = min_reg;
        bias_next = bias_reg;
        if (ctrl.clear) begin
            sum_next = '0;
            max_next = '0;
            min_next = '0;
        end else if (ctrl.accum) begin
            sum_next = sum_reg + term;
            if (sample > max_reg) begin
                max_next = sample;
            end
            if (sample < min_reg) begin
                min_next = sample;
            end
        end
        if (ctrl.bias_mid) begin
            bias_next = mid_adj[SAMPLE_W:1];
        end else if (div_done) begin
            bias_next = quotient;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            max_reg  <= '0;
            min_reg  <= '0;
            bias_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            max_reg  <= max_next;
            min_reg  <= min_next;
            bias_reg <= bias_next;
        end
    end

    // Corrected sample wraps to 16 bits.
    assign result = ctrl.correct_sel ? (sample - bias_reg) : bias_reg;

endmodule

FILE: rtl/core/bcal_merge.sv
// ============================================================================
// bcal_merge
// Gathers the three lane results and the run flags into the output register.
// ============================================================================
module bcal_merge
    import bcal_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [SAMPLE_W-1:0] lane_x,
    input  logic [SAMPLE_W-1:0] lane_y,
    input  logic [SAMPLE_W-1:0] lane_z,
    input  out_flags_t          flags,
    output logic                can_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // out_x, out_y, out_z
    output logic [7:0]          m_tuser    // run_done, bias_valid, zero pad
);

    logic        valid_reg, valid_next;
    logic [47:0] data_reg, data_next;
    logic [1:0]  user_reg, user_next;

    // The register takes a new result when empty or being drained.
    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = {lane_z, lane_y, lane_x};
            user_next  = {flags.bias_valid, flags.run_done};
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = {6'b0, user_reg};

endmodule

FILE: rtl/core/three_axis_bias_calibrator_top.sv
// ============================================================================
// three_axis_bias_calibrator_top
// Three-axis sensor bias calibrator: corrects samples by a stored bias and
// builds new biases from runs of calibration samples, by mean or midpoint.
//
// Channel   Dir  Signals                       Contents
// s_        in   s_tvalid/s_tready/s_tdata     x, y, z samples; tuser command
// m_        out  m_tvalid/m_tready/m_tdata     out x, y, z; tuser run_done,
//                                               bias_valid
// cfg_      in   cfg_valid/cfg_ready           cfg_addr index, cfg_data value
//
// An item passes from the transfer through S_EXEC and S_OUT to the result
// register; one that ends a run also passes S_FIN, and one that ends a mean
// run waits in S_DIV on the 32-step serial divider in each lane. The input is
// ready again in the cycle after the load, so items are taken one at a time.
// Reset is synchronous and clears the bias, the run and the configuration to
// their defaults. A stalled result holds the block only at result load time.
// ============================================================================
module three_axis_bias_calibrator_top
    import bcal_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample_x, sample_y, sample_z
    input  logic [7:0]  s_tuser,   // command, zero pad
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_x, out_y, out_z
    output logic [7:0]  m_tuser,   // run_done, bias_valid, zero pad
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam int TW = (COUNT_WIDTH > COUNT_REG_W) ? COUNT_WIDTH : COUNT_REG_W;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FIN, S_DIV, S_OUT} state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 cmd_reg, cmd_next;
    logic signed [SAMPLE_W-1:0] sx_reg, sx_next;
    logic signed [SAMPLE_W-1:0] sy_reg, sy_next;
    logic signed [SAMPLE_W-1:0] sz_reg, sz_next;
    logic [COUNT_WIDTH-1:0]     run_count_reg, run_count_next;
    logic                       have_bias_reg, have_bias_next;
    logic                       done_reg, done_next;

    logic                       mode_reg;
    logic [COUNT_REG_W-1:0]     count_reg;
    logic [GRAVITY_W-1:0]       gravity_reg;

    logic [TW-1:0]              count_ext;
    logic [TW-1:0]              cap_ext;
    logic [COUNT_WIDTH-1:0]     target;
    logic [COUNT_WIDTH-1:0]     count_inc;
    lane_ctrl_t                 ctrl;
    logic                       div_done_x, div_done_y, div_done_z;
    logic [SAMPLE_W-1:0]        res_x, res_y, res_z;
    logic                       can_load;
    logic                       load;
    out_flags_t                 flags;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_RST;
            count_reg   <= COUNT_RST;
            gravity_reg <= GRAVITY_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_MODE:    mode_reg    <= cfg_data[0];
                CFG_COUNT:   count_reg   <= cfg_data[COUNT_REG_W-1:0];
                CFG_GRAVITY: gravity_reg <= cfg_data[GRAVITY_W-1:0];
                default:     ;
            endcase
        end
    end

    // Run length: the configured count, at least one, at most the counter.
    assign count_ext = TW'(count_reg);
    assign cap_ext   = TW'({COUNT_WIDTH{1'b1}});
    always_comb begin
        if (count_ext == '0) begin
            target = COUNT_WIDTH'(1);
        end else if (count_ext > cap_ext) begin
            target = {COUNT_WIDTH{1'b1}};
        end else begin
            target = count_ext[COUNT_WIDTH-1:0];
        end
    end

    assign count_inc = run_count_reg + 1'b1;

    // Sequencer next state and lane control.
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        sz_next        = sz_reg;
        run_count_next = run_count_reg;
        have_bias_next = have_bias_reg;
        done_next      = done_reg;
        ctrl           = '0;
        ctrl.correct_sel = (cmd_reg == CMD_CORRECT);
        load           = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser[1:0];
                    sx_next    = s_tdata[15:0];
                    sy_next    = s_tdata[31:16];
                    sz_next    = s_tdata[47:32];
                    done_next  = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_OUT;
                if (cmd_reg == CMD_CALIB) begin
                    ctrl.accum = 1'b1;
                    if (count_inc >= target) begin
                        run_count_next = '0;
                        done_next      = 1'b1;
                        state_next     = S_FIN;
                    end else begin
                        run_count_next = count_inc;
                    end
                end else if (cmd_reg == CMD_RESTART) begin
                    ctrl.clear     = 1'b1;
                    run_count_next = '0;
                end
            end
            S_FIN: begin
                ctrl.clear = 1'b1;
                if (mode_reg == MODE_MID) begin
                    ctrl.bias_mid  = 1'b1;
                    have_bias_next = 1'b1;
                    state_next     = S_OUT;
                end else begin
                    ctrl.div_start = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done_x && div_done_y && div_done_z) begin
                    have_bias_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (can_load) begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            run_count_reg <= '0;
            have_bias_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_count_reg <= run_count_next;
            have_bias_reg <= have_bias_next;
            done_reg      <= done_next;
        end
        cmd_reg <= cmd_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        sz_reg  <= sz_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    // Axis lanes; only z carries the gravity offset.
    bcal_lane #(.COUNT_WIDTH (COUNT_WIDTH)) u_lane_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sample   (sx_reg),
        .offset   ('0),
        .target   (target),
        .div_done (div_done_x),
        .result   (res_x)
    );

    bcal_lane #(.COUNT_WIDTH (COUNT_WIDTH)) u_lane_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sample   (sy_reg),
        .offset   ('0),
        .target   (target),
        .div_done (div_done_y),
        .result   (res_y)
    );

    bcal_lane #(.COUNT_WIDTH (COUNT_WIDTH)) u_lane_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sample   (sz_reg),
        .offset   (gravity_reg),
        .target   (target),
        .div_done (div_done_z),
        .result   (res_z)
    );

    // Merge the lane results into the output register.
    assign flags.run_done   = done_reg;
    assign flags.bias_valid = have_bias_reg;

    bcal_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .lane_x   (res_x),
        .lane_y   (res_y),
        .lane_z   (res_z),
        .flags    (flags),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A result that ends a run always reports a valid bias.
    a_done_has_bias: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tuser[1])
        else $error("run_done result without bias_valid");

    // The block takes no item in the cycle after a transfer.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    // Once a bias exists it stays until reset.
    a_bias_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        !$fell(have_bias_reg))
        else $error("bias_valid dropped without reset");

    // The lane dividers finish together.
    a_lanes_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_done_x == div_done_y) && (div_done_y == div_done_z))
        else $error("lane dividers out of step");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the three-axis bias calibrator. A queue of sample
// transfers feeds a bursty driver; a stalling receiver and a monitor compare
// every result against a cycle-free prediction of bias, run and flag state.
// ============================================================================
module tb_top;
    import bcal_pkg::*;

    // Command code that the block must ignore.
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 1_000_000;

    // One sample transfer and one result transfer, axes x, y, z from index 0.
    typedef struct packed {
        logic [1:0]       command;
        logic [2:0][15:0] smp;
    } sample_item_t;

    typedef struct packed {
        logic [2:0][15:0] axis;
        logic             run_done;
        logic             bias_valid;
    } bias_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic [7:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_data  = '0;

    three_axis_bias_calibrator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // Queues between stimulus, driver and monitor.
    sample_item_t pending_samples[$];
    bias_result_t expected_outputs[$];

    // Predicted configuration and calibration state.
    logic        mode_reg;
    logic [9:0]  run_len_reg;
    logic [14:0] gravity_reg;
    logic [15:0] bias_reg[3];
    logic        bias_seen;
    logic [31:0] run_sum[3];
    int          run_max[3];
    int          run_min[3];
    logic [9:0]  run_count;

    int           error_count = 0;
    int           cycle_count = 0;
    sample_item_t cur_item;
    int           burst_left  = 0;
    int           gap_left    = 0;
    bit           hold_request = 1'b0;
    int           hold_left   = 0;
    int           style_left  = 0;
    int           stall_style = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void clear_run();
        for (int k = 0; k < 3; k++) begin
            run_sum[k] = '0;
            run_max[k] = 0;
            run_min[k] = 0;
        end
        run_count = '0;
    endfunction

    // Advance the predicted state by one accepted sample and queue its result.
    function automatic void compute_calibrated_output(input sample_item_t it);
        bias_result_t r;
        int           v;
        int           s;
        int           q;
        int           target;
        r.run_done = 1'b0;
        case (it.command)
            CMD_CORRECT: begin
                for (int k = 0; k < 3; k++)
                    r.axis[k] = it.smp[k] - bias_reg[k];
            end
            CMD_CALIB: begin
                // A zero count behaves as a run of one sample.
                target = (run_len_reg == 0) ? 1 : int'(run_len_reg);
                for (int k = 0; k < 3; k++) begin
                    s = int'($signed(it.smp[k]));
                    v = s;
                    if (k == 2)
                        v = v - int'(gravity_reg);
                    run_sum[k] = run_sum[k] + v;
                    if (s > run_max[k])
                        run_max[k] = s;
                    if (s < run_min[k])
                        run_min[k] = s;
                end
                run_count = run_count + 1'b1;
                if (run_count >= target) begin
                    // Both divides truncate toward zero; the bias wraps to 16 bits.
                    for (int k = 0; k < 3; k++) begin
                        if (mode_reg == MODE_MEAN)
                            q = $signed(run_sum[k]) / target;
                        else
                            q = (run_max[k] + run_min[k]) / 2;
                        bias_reg[k] = q[15:0];
                    end
                    bias_seen  = 1'b1;
                    r.run_done = 1'b1;
                    clear_run();
                end
            end
            CMD_RESTART: clear_run();
            default: ;
        endcase
        if (it.command != CMD_CORRECT)
            for (int k = 0; k < 3; k++)
                r.axis[k] = bias_reg[k];
        r.bias_valid = bias_seen;
        expected_outputs.push_back(r);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                compute_calibrated_output(cur_item);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    cur_item = pending_samples.pop_front();
                    s_tdata  <= cur_item.smp;
                    s_tuser  <= {6'b0, cur_item.command};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 50);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall style changes at random intervals; one long hold on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(50, 300);
            end else begin
                style_left--;
            end
            case (stall_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%04h, got 0x%04h", name, want, got);
            error_count++;
        end
    endtask

    // Monitor: each result transfer is matched against the oldest prediction.
    always @(posedge aclk) begin
        bias_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outputs.size() == 0) begin
                $error("result transfer with no prediction pending: tdata 0x%012h",
                       m_tdata);
                error_count++;
            end else begin
                want = expected_outputs.pop_front();
                check_field("out_x", want.axis[0], m_tdata[15:0]);
                check_field("out_y", want.axis[1], m_tdata[31:16]);
                check_field("out_z", want.axis[2], m_tdata[47:32]);
                check_field("run_done", {15'b0, want.run_done}, {15'b0, m_tuser[0]});
                check_field("bias_valid", {15'b0, want.bias_valid}, {15'b0, m_tuser[1]});
            end
        end
    end

    function automatic void push_item(input logic [1:0] cmd, input logic [15:0] x,
                                      input logic [15:0] y, input logic [15:0] z);
        sample_item_t it;
        it.command = cmd;
        it.smp[0]  = x;
        it.smp[1]  = y;
        it.smp[2]  = z;
        pending_samples.push_back(it);
    endfunction

    // Mostly full-range values, with the corners mixed in.
    function automatic logic [15:0] rand_sample();
        logic [15:0] corners[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 4)];
        return 16'($urandom);
    endfunction

    // Calibration samples dominate so that runs complete often.
    function automatic logic [1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) return CMD_CALIB;
        if (r < 90) return CMD_CORRECT;
        if (r < 95) return CMD_RESTART;
        return CMD_UNUSED;
    endfunction

    function automatic logic [9:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 10'd0;
        if (r == 1) return 10'($urandom_range(13, 80));
        return 10'($urandom_range(1, 12));
    endfunction

    function automatic logic [14:0] pick_gravity();
        case ($urandom_range(0, 3))
            0: return 15'd0;
            1: return 15'h7fff;
            2: return 15'd16384;
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    // Block until every sample is accepted and every result has come back.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_tvalid || expected_outputs.size() != 0)
            @(posedge aclk);
    endtask

    // Write all three registers back to back; valid drops only after the last.
    task automatic write_settings(input logic mode, input logic [9:0] count,
                                  input logic [14:0] gravity);
        logic [1:0]  idx[3];
        logic [15:0] val[3];
        idx = '{CFG_MODE, CFG_COUNT, CFG_GRAVITY};
        val = '{{15'b0, mode}, {6'b0, count}, {1'b0, gravity}};
        for (int i = 0; i < 3; i++) begin
            cfg_addr  <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                CFG_MODE:  mode_reg    = val[i][0];
                CFG_COUNT: run_len_reg = val[i][9:0];
                default:   gravity_reg = val[i][14:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed corners, one long run under back pressure, random phases.
    initial begin
        int n;
        int random_items;
        logic [1:0] cmd;
        mode_reg    = MODE_RST;
        run_len_reg = COUNT_RST;
        gravity_reg = GRAVITY_RST;
        for (int k = 0; k < 3; k++)
            bias_reg[k] = '0;
        bias_seen = 1'b0;
        clear_run();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: correction before any bias, ignored command, partial run.
        push_item(CMD_CORRECT, 16'h7fff, 16'h8000, 16'h0000);
        push_item(CMD_CORRECT, 16'hffff, 16'h0001, 16'h7fff);
        push_item(CMD_UNUSED,  16'h1234, 16'h5678, 16'h9abc);
        push_item(CMD_CALIB,   16'h7fff, 16'h8000, 16'h8000);
        push_item(CMD_RESTART, 16'h0000, 16'h0000, 16'h0000);
        push_item(CMD_CALIB,   16'h0001, 16'h0002, 16'h0003);
        wait_idle();

        // Single-sample mean runs with full gravity: z quotient wraps.
        write_settings(MODE_MEAN, 10'd1, 15'h7fff);
        push_item(CMD_CALIB,   16'h8000, 16'h7fff, 16'h8000);
        push_item(CMD_CORRECT, 16'h8000, 16'h7fff, 16'h7fff);
        push_item(CMD_CALIB,   16'h7fff, 16'h8000, 16'h7fff);
        wait_idle();

        // Zero sample count acts as one.
        write_settings(MODE_MEAN, 10'd0, 15'd0);
        push_item(CMD_CALIB,   16'hfffd, 16'h0005, 16'h8000);
        push_item(CMD_UNUSED,  16'hffff, 16'hffff, 16'hffff);
        wait_idle();

        // Mean of negative sums truncates toward zero.
        write_settings(MODE_MEAN, 10'd2, 15'd0);
        push_item(CMD_CALIB,   16'hfffd, 16'h0003, 16'h7fff);
        push_item(CMD_CORRECT, 16'h0000, 16'h0000, 16'h0000);
        push_item(CMD_CALIB,   16'hfffe, 16'h0002, 16'h7fff);
        wait_idle();

        // Midpoint with max and min starting at zero, restart mid-run.
        write_settings(MODE_MID, 10'd2, 15'd16384);
        push_item(CMD_CALIB,   16'h7fff, 16'h8000, 16'h0010);
        push_item(CMD_CALIB,   16'h8000, 16'h7fff, 16'h0003);
        push_item(CMD_CALIB,   16'h8000, 16'h8000, 16'h8000);
        push_item(CMD_RESTART, 16'h7fff, 16'h7fff, 16'h7fff);
        push_item(CMD_CALIB,   16'h0005, 16'hfff9, 16'h0001);
        push_item(CMD_CALIB,   16'hfff9, 16'h0005, 16'hffff);
        push_item(CMD_CORRECT, 16'h8000, 16'h7fff, 16'h0000);
        wait_idle();

        // Longest run with the receiver held off while the sender keeps offering.
        write_settings(MODE_MEAN, 10'd1023, 15'h7fff);
        for (int i = 0; i < 1100; i++) begin
            cmd = ($urandom_range(0, 9) == 0) ? CMD_CORRECT : CMD_CALIB;
            push_item(cmd, rand_sample(), rand_sample(), rand_sample());
        end
        hold_request = 1'b1;
        wait_idle();

        // Random phases with random settings.
        random_items = 1100;
        while (random_items < 2000) begin
            n = $urandom_range(40, 160);
            write_settings(1'($urandom_range(0, 1)), pick_count(), pick_gravity());
            for (int i = 0; i < n; i++)
                push_item(pick_command(), rand_sample(), rand_sample(), rand_sample());
            random_items += n;
            wait_idle();
        end

        repeat (64) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
